// ===== rtl/aes_block_cipher_macros.svh =====
// Assertion macros for the port-level checker
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH
// implication checked every edge outside reset
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/aes_pkg.sv =====
// ---------------------------------------------------------------------------
// aes_pkg
// Constants, tables and byte functions for the AES cipher.
// ---------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

    localparam int unsigned KeyWords = 60;
    localparam int unsigned RkAddrW  = 6;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_SIZE = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_stream_if.sv =====
// ---------------------------------------------------------------------------
// aes_stream_if
// Valid/ready channel carrying a generic payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface aes_stream_if #(
    parameter int unsigned W = 129
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/aes_round.sv =====
// ---------------------------------------------------------------------------
// aes_round
// One shared cipher round: forward or inverse, with or without mix step.
// ---------------------------------------------------------------------------
`default_nettype none
module aes_round
    import aes_pkg::*;
(
    input  wire logic [127:0] state,
    input  wire logic [127:0] rkey,
    input  wire logic         dec,
    input  wire logic         mix,
    output logic      [127:0] result
);
    logic [7:0] s  [16];
    logic [7:0] t  [16];
    logic [7:0] k  [16];
    logic [7:0] m  [16];
    logic [7:0] a  [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state[127-8*i -: 8];
            k[i] = rkey[127-8*i -: 8];
        end
        // byte i = 4*c + r
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (dec)
                    t[4*c+r] = ISBOX[s[4*((c+4-r)%4)+r]];
                else
                    t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
            end
        // decrypt adds the key before mixing
        for (int i = 0; i < 16; i++)
            a[i] = dec ? (t[i] ^ k[i]) : t[i];
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] x0, x1, x2, x3, u, v;
            x0 = a[4*c]; x1 = a[4*c+1]; x2 = a[4*c+2]; x3 = a[4*c+3];
            u = xt(xt(x0 ^ x2));
            v = xt(xt(x1 ^ x3));
            if (dec)
            begin
                x0 = x0 ^ u; x1 = x1 ^ v; x2 = x2 ^ u; x3 = x3 ^ v;
            end
            u = x0 ^ x1 ^ x2 ^ x3;
            m[4*c]   = x0 ^ u ^ xt(x0 ^ x1);
            m[4*c+1] = x1 ^ u ^ xt(x1 ^ x2);
            m[4*c+2] = x2 ^ u ^ xt(x2 ^ x3);
            m[4*c+3] = x3 ^ u ^ xt(x3 ^ x0);
        end
        for (int i = 0; i < 16; i++)
        begin
            if (dec)
                result[127-8*i -: 8] = mix ? m[i] : a[i];
            else
                result[127-8*i -: 8] = (mix ? m[i] : a[i]) ^ k[i];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/aes_block_cipher.sv =====
// ---------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 ECB encrypt and decrypt with an on-chip key schedule.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready, data = {req_type, block_high, block_low}.
//   out_ch : valid/ready, data = {result_high, result_low}.
//   cfg    : cfg_we/cfg_index/cfg_data write the key words and key size.
// After a key-word or key-size write the next block first expands the key
// schedule, one 32-bit word per cycle into a 60 x 32 round-key memory:
// 44, 52 or 60 words. Each block then takes one load state, then for each
// of the Nr+1 rounds a fetch state that reads four round-key words through
// the registered memory read and a round state through the shared round
// unit; these steps share the single round-key memory port and round unit.
// in ready is low while a block is in work or its result waits; a stalled
// receiver holds the result register and the block waits with it.
// Reset clears control, key registers and the schedule flag; the round-key
// memory holds no reset value and is always written before a block uses it.
// ---------------------------------------------------------------------------
`default_nettype none
module aes_block_cipher
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    aes_stream_if.sink       in_ch,
    aes_stream_if.source     out_ch
);
    typedef enum logic [2:0] {S_IDLE, S_EXP, S_LOAD, S_FETCH, S_RND, S_OUT} st_t;

    st_t          st_reg;
    logic [255:0] key_reg;
    logic [1:0]   ksize_reg;
    logic         sched_ok_reg;
    logic [31:0]  rk_mem [KeyWords];
    logic [31:0]  rk_rd_reg;
    logic [31:0]  win_reg [8];
    logic [RkAddrW-1:0] wi_reg;
    logic [2:0]   kc_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] blk_reg;
    logic         dec_reg;
    logic [127:0] st_data_reg;
    logic [127:0] rk_reg;
    logic [3:0]   rnd_reg;
    logic [2:0]   fc_reg;
    logic         first_reg;

    logic [3:0]   nr;
    logic [2:0]   nk;
    logic [RkAddrW-1:0] total;
    logic [31:0]  tmp, nw;
    logic [RkAddrW-1:0] rd_addr;
    logic [127:0] rout;
    logic         last;

    always_comb
    begin
        unique case (ksize_reg)
            KEY_128: begin nr = 4'd10; nk = 3'd4; end
            KEY_192: begin nr = 4'd12; nk = 3'd6; end
            default: begin nr = 4'd14; nk = 3'd0; end
        endcase
        total = RkAddrW'({nr, 2'b00} + 6'd4);
    end

    // key expansion word, window holds the last eight words, newest on top
    always_comb
    begin
        tmp = win_reg[7];
        if (kc_reg == 3'd0)
            tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_reg, 24'd0};
        else if (nk == 3'd0 && kc_reg == 3'd4)
            tmp = sub_word(tmp);
        nw = win_reg[3'd0 - nk] ^ tmp;
    end

    logic [3:0] kr;
    assign kr   = dec_reg ? (nr - rnd_reg) : rnd_reg;
    assign last = (rnd_reg == nr);
    assign rd_addr = RkAddrW'({kr, 2'b00} + {4'd0, fc_reg[1:0]});

    aes_round u_round (
        .state  (st_data_reg),
        .rkey   (rk_reg),
        .dec    (dec_reg),
        .mix    (!last),
        .result (rout)
    );

    always_ff @(posedge clk)
    begin
        if (st_reg == S_EXP)
            rk_mem[wi_reg] <= (wi_reg < RkAddrW'(nk == 3'd0 ? 4'd8 : {1'b0, nk}))
                ? key_reg[255 - 32*wi_reg[2:0] -: 32] : nw;
        rk_rd_reg <= rk_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            key_reg      <= '0;
            ksize_reg    <= KEY_128;
            sched_ok_reg <= 1'b0;
            wi_reg       <= '0;
            kc_reg       <= '0;
            rcon_reg     <= 8'h01;
            rnd_reg      <= '0;
            fc_reg       <= '0;
            first_reg    <= 1'b0;
            dec_reg      <= 1'b0;
            blk_reg      <= '0;
            st_data_reg  <= '0;
            rk_reg       <= '0;
            for (int i = 0; i < 8; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY0: begin key_reg[255:192] <= cfg_data; sched_ok_reg <= 1'b0; end
                    CFG_KEY1: begin key_reg[191:128] <= cfg_data; sched_ok_reg <= 1'b0; end
                    CFG_KEY2: begin key_reg[127:64]  <= cfg_data; sched_ok_reg <= 1'b0; end
                    CFG_KEY3: begin key_reg[63:0]    <= cfg_data; sched_ok_reg <= 1'b0; end
                    CFG_SIZE:
                    begin
                        ksize_reg    <= (cfg_data[1:0] == 2'd3) ? KEY_256 : cfg_data[1:0];
                        sched_ok_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            unique case (st_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        blk_reg <= in_ch.data[127:0];
                        dec_reg <= in_ch.data[128];
                        wi_reg  <= '0;
                        kc_reg  <= '0;
                        rcon_reg <= 8'h01;
                        st_reg  <= sched_ok_reg ? S_LOAD : S_EXP;
                    end
                S_EXP:
                begin
                    for (int i = 0; i < 7; i++)
                        win_reg[i] <= win_reg[i+1];
                    win_reg[7] <= (wi_reg < RkAddrW'(nk == 3'd0 ? 4'd8 : {1'b0, nk}))
                        ? key_reg[255 - 32*wi_reg[2:0] -: 32] : nw;
                    if (wi_reg >= RkAddrW'(nk == 3'd0 ? 4'd8 : {1'b0, nk}))
                    begin
                        if (kc_reg == 3'd0)
                            rcon_reg <= xt(rcon_reg);
                        kc_reg <= (kc_reg == nk - 3'd1) ? 3'd0 : kc_reg + 3'd1;
                    end
                    wi_reg <= wi_reg + 1'b1;
                    if (wi_reg == total - 1'b1)
                    begin
                        sched_ok_reg <= 1'b1;
                        st_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    rnd_reg   <= '0;
                    fc_reg    <= '0;
                    first_reg <= 1'b1;
                    st_reg    <= S_FETCH;
                end
                S_FETCH:
                begin
                    // read data arrives in the cycle after its address
                    fc_reg <= fc_reg + 1'b1;
                    if (fc_reg != 3'd0)
                        rk_reg <= {rk_reg[95:0], rk_rd_reg};
                    if (fc_reg == 3'd4)
                        st_reg <= S_RND;
                end
                S_RND:
                begin
                    fc_reg <= '0;
                    if (first_reg)
                        st_data_reg <= blk_reg ^ rk_reg;
                    else
                        st_data_reg <= rout;
                    first_reg <= 1'b0;
                    if (!first_reg && last)
                        st_reg <= S_OUT;
                    else
                    begin
                        rnd_reg <= first_reg ? rnd_reg + 4'd1 :
                                   (last ? rnd_reg : rnd_reg + 4'd1);
                        st_reg  <= S_FETCH;
                    end
                end
                S_OUT:
                    if (out_ch.ready)
                        st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready  = (st_reg == S_IDLE);
    assign out_ch.valid = (st_reg == S_OUT);
    assign out_ch.data  = st_data_reg;
endmodule
`default_nettype wire

// ===== rtl/aes_block_cipher_chk.sv =====
// ---------------------------------------------------------------------------
// aes_block_cipher_chk
// Port-level checks for the AES block cipher.
// ---------------------------------------------------------------------------
`default_nettype none
`include "aes_block_cipher_macros.svh"
module aes_block_cipher_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [127:0] out_data
);
    `AES_ASSERT_IMP(a_excl, clk, rst_n, in_ready, !out_valid)
    `AES_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    `AES_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `AES_ASSERT_NXT(a_done, clk, rst_n, out_valid && out_ready, in_ready)
endmodule

bind aes_block_cipher aes_block_cipher_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
`default_nettype wire
